@@ rtl/modular_inverse_ext_euclid_core_defines.svh @@
// ----------------------------------------------------------------------------
// modular inverse core: assertion macros
// shared by the modules that carry concurrent checks
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_CORE_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_CORE_DEFINES_SVH

// same-cycle implication
`define MEIE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("modular inverse core: check failed");

// next-cycle implication
`define MEIE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("modular inverse core: check failed");

`endif

@@ rtl/meie_pkg.sv @@
// ----------------------------------------------------------------------------
// meie_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package meie_pkg;

	localparam int OPERAND_WIDTH_DEF = 32;
	localparam int INV_W             = 32;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic update;
		logic reduce;
		logic out_load;
	} meie_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic mod_zero;
		logic rem_zero;
	} meie_sts_t;

endpackage

`default_nettype wire

@@ rtl/modular_inverse_ext_euclid_core.sv @@
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid_core: modular inverse by extended euclid
// one word at a time; each round is a bit-serial division plus an update step;
// a reduce step follows the last round, or the load when the modulus is zero,
// then the result waits in the done state until the output register is free
// arst_n clears the sequencer and the output valid; no result pending after it
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_inverse_ext_euclid_core_defines.svh"

module modular_inverse_ext_euclid_core #(
	parameter int OPERAND_WIDTH = meie_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [OPERAND_WIDTH-1:0]    value,
	input  wire logic [OPERAND_WIDTH-1:0]    modulus,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [meie_pkg::INV_W-1:0]  inverse,
	output logic                             zero_modulus_error
);

	meie_pkg::meie_cmd_t        cmd;
	meie_pkg::meie_sts_t        sts;
	logic [meie_pkg::INV_W-1:0] dp_res;
	logic                       dp_err;
	logic                       out_free;

	logic                       out_valid_q;
	logic [meie_pkg::INV_W-1:0] inverse_q;
	logic                       err_q;

	meie_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.out_free (out_free),
		.cmd      (cmd)
	);

	meie_datapath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.value   (value),
		.modulus (modulus),
		.res     (dp_res),
		.err     (dp_err)
	);

	// output word register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			inverse_q <= dp_res;
			err_q     <= dp_err;
		end
	end

	assign out_valid          = out_valid_q;
	assign inverse            = inverse_q;
	assign zero_modulus_error = err_q;

	`MEIE_ASSERT_IMP(a_err_inverse_zero, clk, arst_n, out_valid_q && err_q, inverse_q == '0)
	`MEIE_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire

@@ rtl/meie_datapath.sv @@
// ----------------------------------------------------------------------------
// meie_datapath
// remainder and coefficient registers, bit-serial divider with fused
// quotient-times-coefficient accumulation, final reduction into 0..m-1
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_inverse_ext_euclid_core_defines.svh"

module meie_datapath #(
	parameter int OPERAND_WIDTH = meie_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire meie_pkg::meie_cmd_t         cmd,
	output meie_pkg::meie_sts_t              sts,
	input  wire logic [OPERAND_WIDTH-1:0]    value,
	input  wire logic [OPERAND_WIDTH-1:0]    modulus,
	output logic      [meie_pkg::INV_W-1:0]  res,
	output logic                             err
);

	localparam int W  = OPERAND_WIDTH;
	localparam int SW = OPERAND_WIDTH + 2;

	logic        [W-1:0]  r1_q, m_q, rem_q, quo_q;
	logic signed [SW-1:0] s0_q, s1_q, acc_q;
	logic [meie_pkg::INV_W-1:0] res_q;
	logic                 err_q;

	logic        [W:0]    trial, diff;
	logic                 qb;
	logic        [W-1:0]  rem_n;
	logic signed [SW-1:0] m_ext, red;

	// one restoring division step
	assign trial = {rem_q, quo_q[W-1]};
	assign diff  = trial - {1'b0, r1_q};
	assign qb    = (trial >= {1'b0, r1_q});
	assign rem_n = qb ? diff[W-1:0] : trial[W-1:0];

	// coefficient magnitude never exceeds the modulus, one correction suffices
	assign m_ext = $signed({2'b00, m_q});
	always_comb begin
		if (s0_q < 0) begin
			red = s0_q + m_ext;
		end else if (s0_q >= m_ext) begin
			red = s0_q - m_ext;
		end else begin
			red = s0_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r1_q  <= modulus;
			m_q   <= modulus;
			s0_q  <= SW'(1);
			s1_q  <= '0;
			quo_q <= value;
			rem_q <= '0;
			acc_q <= '0;
			err_q <= (modulus == '0);
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[W-2:0], qb};
			// horner form of q * s1, msb of q first
			acc_q <= (acc_q <<< 1) + (qb ? s1_q : '0);
		end else if (cmd.update) begin
			r1_q  <= rem_q;
			s0_q  <= s1_q;
			s1_q  <= s0_q - acc_q;
			quo_q <= r1_q;
			rem_q <= '0;
			acc_q <= '0;
		end
		if (cmd.reduce) begin
			res_q <= err_q ? '0 : meie_pkg::INV_W'($unsigned(red));
		end
	end

	assign sts.mod_zero = (modulus == '0);
	assign sts.rem_zero = (rem_q == '0);
	assign res          = res_q;
	assign err          = err_q;

	`MEIE_ASSERT_IMP(a_coeff_bound, clk, arst_n, cmd.reduce && !err_q,
		(s0_q <= m_ext) && (s0_q >= -m_ext))
	`MEIE_ASSERT_NXT(a_err_zero_res, clk, arst_n, cmd.reduce && err_q, res_q == '0)

endmodule

`default_nettype wire

@@ rtl/meie_ctrl.sv @@
// ----------------------------------------------------------------------------
// meie_ctrl
// sequencer for the euclid rounds: division bit count, update, reduce, hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "modular_inverse_ext_euclid_core_defines.svh"

module meie_ctrl #(
	parameter int OPERAND_WIDTH = meie_pkg::OPERAND_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire meie_pkg::meie_sts_t sts,
	input  wire logic                out_free,
	output meie_pkg::meie_cmd_t      cmd
);

	localparam int CW = $clog2(OPERAND_WIDTH);
	localparam logic [CW-1:0] LAST_BIT = CW'(OPERAND_WIDTH - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DIV    = 5'b00010,
		ST_UPDATE = 5'b00100,
		ST_REDUCE = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = sts.mod_zero ? ST_REDUCE : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == LAST_BIT) begin
					state_d = ST_UPDATE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				cnt_d      = '0;
				// new remainder zero ends the rounds
				state_d    = sts.rem_zero ? ST_REDUCE : ST_DIV;
			end
			ST_REDUCE: begin
				cmd.reduce = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	`MEIE_ASSERT_NXT(a_div_ends, clk, arst_n, (state_q == ST_DIV) && (cnt_q == LAST_BIT),
		state_q == ST_UPDATE)
	`MEIE_ASSERT_NXT(a_update_next, clk, arst_n, state_q == ST_UPDATE,
		(state_q == ST_DIV) || (state_q == ST_REDUCE))

endmodule

`default_nettype wire

@@ test/tb_modular_inverse_ext_euclid_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_inverse_ext_euclid_core
// drives value/modulus words into the core, predicts each inverse with a
// 64-bit extended euclid and checks every result word in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_modular_inverse_ext_euclid_core;

	localparam int OPW         = meie_pkg::OPERAND_WIDTH_DEF;
	localparam int INVW        = meie_pkg::INV_W;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int IDLE_PCT    = 31;
	localparam int N_RANDOM    = 348;
	localparam int DRAIN_AT    = 250;
	localparam int END_CYCLES  = 50;

	typedef struct packed {
		logic [OPW-1:0] value;
		logic [OPW-1:0] modulus;
	} operand_pair_t;

	typedef struct packed {
		logic [INVW-1:0] inverse;
		logic            zero_modulus_error;
	} inv_result_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	logic [OPW-1:0]  value = '0;
	logic [OPW-1:0]  modulus = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic [INVW-1:0] inverse;
	logic            zero_modulus_error;

	operand_pair_t pending_pairs[$];
	inv_result_t   expected_inverses[$];
	operand_pair_t next_pair;
	inv_result_t   want;
	logic          in_taken = 1'b0;
	int            words_sent = 0;
	int            results_seen = 0;
	int            err_count = 0;
	int            cycle_count = 0;
	logic          calm;

	modular_inverse_ext_euclid_core u_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.value              (value),
		.modulus            (modulus),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.inverse            (inverse),
		.zero_modulus_error (zero_modulus_error)
	);

	// stretch of the random part with no idling on either side
	assign calm = (words_sent >= 120) && (words_sent < 200);

	// coefficients kept modulo 2^64, then reduced into 0 .. m-1
	function automatic inv_result_t predict_inverse(input logic [OPW-1:0] a,
			input logic [OPW-1:0] m);
		logic [63:0] r0, r1, r2, s0, s1, s2, q, mm, rem;
		inv_result_t res;
		res.inverse = '0;
		res.zero_modulus_error = 1'b0;
		if (m == '0) begin
			res.zero_modulus_error = 1'b1;
			return res;
		end
		r0 = a;
		r1 = m;
		s0 = 64'd1;
		s1 = 64'd0;
		while (r1 != 64'd0) begin
			q  = r0 / r1;
			r2 = r0 - q * r1;
			s2 = s0 - q * s1;
			r0 = r1;
			r1 = r2;
			s0 = s1;
			s1 = s2;
		end
		mm = m;
		if (s0[63]) begin
			rem = (64'd0 - s0) % mm;
			res.inverse = (rem == 64'd0) ? '0 : INVW'(mm - rem);
		end else begin
			res.inverse = INVW'(s0 % mm);
		end
		return res;
	endfunction

	task automatic push_pair(input logic [OPW-1:0] a, input logic [OPW-1:0] m);
		operand_pair_t p;
		p.value = a;
		p.modulus = m;
		pending_pairs.push_back(p);
	endtask

	// every queued word sent and every result word back
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_pairs.size() != 0 || words_sent != results_seen);
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// driver: inputs move on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_pairs.size() != 0 &&
						(calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_pair = pending_pairs.pop_front();
					value      <= next_pair.value;
					modulus    <= next_pair.modulus;
					in_valid   <= 1'b1;
					words_sent <= words_sent + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// monitor: both channels sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall)
				expected_inverses.push_back(predict_inverse(value, modulus));
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (expected_inverses.size() == 0) begin
					$error("result word with none expected: inverse %0h, zero_modulus_error %0b",
						inverse, zero_modulus_error);
					err_count = err_count + 1;
				end else begin
					want = expected_inverses.pop_front();
					if (inverse !== want.inverse) begin
						$error("inverse: expected %0h, actual %0h", want.inverse, inverse);
						err_count = err_count + 1;
					end
					if (zero_modulus_error !== want.zero_modulus_error) begin
						$error("zero_modulus_error: expected %0b, actual %0b",
							want.zero_modulus_error, zero_modulus_error);
						err_count = err_count + 1;
					end
				end
			end
		end
	end

	initial begin
		logic [OPW-1:0] a, m;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero modulus
		push_pair(32'd3, 32'd0);
		push_pair(32'd0, 32'd0);
		push_pair(32'hFFFF_FFFF, 32'd0);
		// zero value
		push_pair(32'd0, 32'd7);
		push_pair(32'd0, 32'hFFFF_FFFF);
		// modulus one
		push_pair(32'd5, 32'd1);
		push_pair(32'hFFFF_FFFF, 32'd1);
		// gcd not one
		push_pair(32'd6, 32'd9);
		push_pair(32'hFFFF_FFFE, 32'hFFFF_FFFE);
		push_pair(32'h8000_0000, 32'h4000_0000);
		// value not below modulus, then value below modulus
		push_pair(32'd7, 32'd3);
		push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
		push_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF);
		push_pair(32'd1, 32'hFFFF_FFFF);
		push_pair(32'd2, 32'hFFFF_FFFF);
		push_pair(32'd3, 32'd7);
		push_pair(32'd1, 32'd2);
		push_pair(32'd12345, 32'd4294967291);
		// consecutive fibonacci numbers give the most rounds; then equal and patterned words
		push_pair(32'd1836311903, 32'd2971215073);
		push_pair(32'd2971215073, 32'd1836311903);
		push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_pair(32'h5555_5555, 32'hAAAA_AAAB);
		wait_drained();

		for (int i = 0; i < N_RANDOM; i++) begin
			case ($urandom_range(0, 19))
				0: begin
					a = $urandom();
					m = '0;
				end
				1, 2, 3: begin
					a = $urandom();
					m = $urandom_range(1, 255);
				end
				4, 5: begin
					a = $urandom() >> $urandom_range(0, 31);
					m = $urandom() >> $urandom_range(0, 31);
				end
				6, 7: begin
					m = $urandom() | 32'd1;
					a = $urandom_range(0, m - 1);
				end
				default: begin
					a = $urandom();
					m = $urandom();
				end
			endcase
			push_pair(a, m);
			if (i == DRAIN_AT)
				wait_drained();
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_inverses.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/meie_pkg.sv
rtl/meie_datapath.sv
rtl/meie_ctrl.sv
rtl/modular_inverse_ext_euclid_core.sv
test/tb_modular_inverse_ext_euclid_core.sv
